FILE: rtl/cgs_pkg.sv
// Package for the cave grid smoothing pass: sizes, register indexes, types and the rule kernel.
package cgs_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int SIZE_W     = 9;
   localparam int CSR_IDX_W  = 8;
   localparam int WIN_W      = 9;
   localparam int RES_N      = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = CSR_IDX_W'(1);

   localparam logic [SIZE_W-1:0] GRID_WIDTH_RST  = SIZE_W'(64);
   localparam logic [SIZE_W-1:0] GRID_HEIGHT_RST = SIZE_W'(64);

   // Neighbor count at which the old value is kept
   localparam int KEEP_COUNT = 4;

   // Result slot codes, in raster order of emission
   localparam logic [1:0] RES_UP_LEFT  = 2'd0;
   localparam logic [1:0] RES_UP_HERE  = 2'd1;
   localparam logic [1:0] RES_CUR_LEFT = 2'd2;
   localparam logic [1:0] RES_CUR_HERE = 2'd3;

   // One accepted cell with its position flags
   typedef struct packed {
      logic             cell_bit;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             row_ge1;
      logic             row_ge2;
      logic             col_ge1;
      logic             col_ge2;
      logic             row_last;
      logic             col_last;
   } item_type;

   // Up to four results caused by one cell
   typedef struct packed {
      logic [RES_N-1:0] mask;
      logic [RES_N-1:0] vals;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } group_type;

   // Clamp a size register to 1..maxv
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                  input logic [SIZE_W-1:0] maxv);
      logic [SIZE_W-1:0] res;
      res = v;
      if (v == '0) res = SIZE_W'(1);
      else if (v > maxv) res = maxv;
      return res;
   endfunction

   // 4-5 rule on the 3x3 window; ro/co shift the center, outside cells count as walls
   function automatic logic smooth_at(input logic [WIN_W-1:0] win,
                                      input int ro, input int co,
                                      input logic r1, input logic r2,
                                      input logic c1, input logic c2);
      int   dr;
      int   dc;
      int   k;
      int   j;
      logic ok;
      logic [3:0] count;
      logic res;
      count = '0;
      for (dr = 0; dr < 3; dr++) begin
         for (dc = 0; dc < 3; dc++) begin
            k = dr + ro;
            j = dc + co;
            if (!(dr == 1 && dc == 1)) begin
               ok = (k <= 2) && (j <= 2)
                  && ((k >= 2) || (k == 1 && r1) || (k == 0 && r2))
                  && ((j >= 2) || (j == 1 && c1) || (j == 0 && c2));
               if (!ok) count = count + 4'd1;
               else if (!win[j*3+k]) count = count + 4'd1;
            end
         end
      end
      if (count > 4'(KEEP_COUNT)) res = 1'b0;
      else if (count < 4'(KEEP_COUNT)) res = 1'b1;
      else res = win[(1+co)*3+(1+ro)];
      return res;
   endfunction

endpackage

FILE: rtl/cgs_if.sv
// Channel interfaces for the cell stream, the result stream and the register write port.
interface cgs_req_if;
   logic valid;
   logic ready;
   logic cell_in;
   modport source (output valid, output cell_in, input ready);
   modport sink (input valid, input cell_in, output ready);
endinterface

interface cgs_rsp_if;
   logic                    valid;
   logic                    ready;
   logic                    cell_out;
   logic [cgs_pkg::ROW_W-1:0] out_row;
   logic [cgs_pkg::COL_W-1:0] out_col;
   logic                    run_last;
   logic                    frame_done;
   modport source (output valid, output cell_out, output out_row, output out_col,
                   output run_last, output frame_done, input ready);
   modport sink (input valid, input cell_out, input out_row, input out_col,
                 input run_last, input frame_done, output ready);
endinterface

interface cgs_csr_if;
   logic                         valid;
   logic                         ready;
   logic [cgs_pkg::CSR_IDX_W-1:0] index;
   logic [cgs_pkg::SIZE_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/cave_grid_smoothing_pass.sv
// Top level of the cave grid smoothing pass: counters, input stage and submodule wiring.
//
//  channel   dir  handshake      payload
//  req_ch    in   valid/ready    cell_in
//  rsp_ch    out  valid/ready    cell_out, out_row, out_col, run_last, frame_done
//  csr_ch    in   valid/ready    index, data (grid_width 0, grid_height 1)
//
// One cell per cycle unless the input stage is held: the line store read is issued at
// acceptance, the window and write-back follow as the input stage advances. Each cell's
// results sit in the result slot and leave one per cycle while rsp is ready, so a row
// end and each last-row cell can carry two results, the grid's final cell up to four.
// Synchronous reset restores 64x64 and clears the counters; a write to a known register
// restarts the frame. A stalled result holds the input stage, which then holds req.
module cave_grid_smoothing_pass (
   input  logic        clock,
   input  logic        reset,
   cgs_req_if.sink     req_ch,
   cgs_rsp_if.source   rsp_ch,
   cgs_csr_if.sink     csr_ch
);

   logic [cgs_pkg::SIZE_W-1:0] width_ff;
   logic [cgs_pkg::SIZE_W-1:0] height_ff;
   logic [cgs_pkg::ROW_W-1:0]  row_ff;
   logic [cgs_pkg::COL_W-1:0]  col_ff;
   logic                       a_valid_ff;
   cgs_pkg::item_type          a_item_ff;
   cgs_pkg::item_type          item_in;
   cgs_pkg::group_type         group;
   logic [cgs_pkg::SIZE_W-1:0] w_eff;
   logic [cgs_pkg::SIZE_W-1:0] h_eff;
   logic [1:0]                 rd_data;
   logic [1:0]                 wr_data;
   logic                       req_acc;
   logic                       csr_acc;
   logic                       csr_hit;
   logic                       a_adv;
   logic                       take_ok;

   assign w_eff = cgs_pkg::eff_size(width_ff, cgs_pkg::SIZE_W'(cgs_pkg::MAX_WIDTH));
   assign h_eff = cgs_pkg::eff_size(height_ff, cgs_pkg::SIZE_W'(cgs_pkg::MAX_HEIGHT));

   // handshakes
   assign csr_ch.ready = 1'b1;
   assign csr_acc      = csr_ch.valid && csr_ch.ready;
   assign csr_hit      = csr_acc && (csr_ch.index == cgs_pkg::REG_GRID_WIDTH
                                  || csr_ch.index == cgs_pkg::REG_GRID_HEIGHT);
   assign a_adv        = a_valid_ff && take_ok;
   assign req_ch.ready = !a_valid_ff || take_ok;
   assign req_acc      = req_ch.valid && req_ch.ready;

   // position flags of the incoming cell
   always_comb begin
      item_in.cell_bit = req_ch.cell_in;
      item_in.row      = row_ff;
      item_in.col      = col_ff;
      item_in.row_ge1  = (row_ff != '0);
      item_in.row_ge2  = (row_ff > cgs_pkg::ROW_W'(1));
      item_in.col_ge1  = (col_ff != '0);
      item_in.col_ge2  = (col_ff > cgs_pkg::COL_W'(1));
      item_in.row_last = ({1'b0, row_ff} == h_eff - cgs_pkg::SIZE_W'(1));
      item_in.col_last = ({1'b0, col_ff} == w_eff - cgs_pkg::SIZE_W'(1));
   end

   // registers, raster counters and input stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= cgs_pkg::GRID_WIDTH_RST;
         height_ff  <= cgs_pkg::GRID_HEIGHT_RST;
         row_ff     <= '0;
         col_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         if (csr_acc && csr_ch.index == cgs_pkg::REG_GRID_WIDTH) width_ff <= csr_ch.data;
         if (csr_acc && csr_ch.index == cgs_pkg::REG_GRID_HEIGHT) height_ff <= csr_ch.data;
         if (csr_hit) begin
            row_ff <= '0;
            col_ff <= '0;
         end else if (req_acc) begin
            if (item_in.col_last) begin
               col_ff <= '0;
               row_ff <= item_in.row_last ? '0 : row_ff + cgs_pkg::ROW_W'(1);
            end else begin
               col_ff <= col_ff + cgs_pkg::COL_W'(1);
            end
         end
         if (req_acc) a_valid_ff <= 1'b1;
         else if (a_adv) a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) a_item_ff <= item_in;
   end

   cgs_line_store u_store (
      .clock   (clock),
      .rd_en   (req_acc),
      .rd_addr (col_ff),
      .wr_en   (a_adv),
      .wr_addr (a_item_ff.col),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   cgs_window u_window (
      .clock   (clock),
      .reset   (reset),
      .clear   (csr_hit),
      .adv     (a_adv),
      .item    (a_item_ff),
      .rd_data (rd_data),
      .wr_data (wr_data),
      .group   (group)
   );

   cgs_result_slot u_slot (
      .clock    (clock),
      .reset    (reset),
      .load     (a_adv),
      .group_in (group),
      .take_ok  (take_ok),
      .rsp      (rsp_ch)
   );

   // the grid's final result always closes its cell's run
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.frame_done |-> rsp_ch.run_last)
      else $error("frame_done without run_last");

   // the final cell of the grid wraps the counters to the origin
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      req_acc && !csr_hit && item_in.row_last && item_in.col_last
      |=> row_ff == '0 && col_ff == '0)
      else $error("counters did not wrap after the final cell");

   // a register write restarts the frame
   a_restart: assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> row_ff == '0 && col_ff == '0)
      else $error("counters not cleared by register write");

   // a held input stage cannot be overwritten
   a_hold: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !take_ok |=> a_valid_ff && $stable(a_item_ff))
      else $error("input stage lost a held cell");

endmodule

FILE: rtl/cgs_line_store.sv
// Two-row line store: one 2-bit word per column, registered read with write forwarding.
module cgs_line_store (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [cgs_pkg::COL_W-1:0] rd_addr,
   input  logic                      wr_en,
   input  logic [cgs_pkg::COL_W-1:0] wr_addr,
   input  logic [1:0]                wr_data,
   output logic [1:0]                rd_data
);

   // bit 0: row two above, bit 1: row one above
   logic [1:0] mem [cgs_pkg::MAX_WIDTH];
   logic [1:0] rd_ff;
   logic [1:0] fwd_data_ff;
   logic       fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   // same column written in the read cycle: take the new word
   assign rd_data = fwd_ff ? fwd_data_ff : rd_ff;

endmodule

FILE: rtl/cgs_window.sv
// 3x3 window register and the rule kernel that forms the result group of one cell.
module cgs_window (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic                 adv,
   input  cgs_pkg::item_type    item,
   input  logic [1:0]           rd_data,
   output logic [1:0]           wr_data,
   output cgs_pkg::group_type   group
);

   logic [cgs_pkg::WIN_W-1:0] window_ff;
   logic [cgs_pkg::WIN_W-1:0] window_in;
   logic [2:0]                colv;

   // new column enters at the top, oldest drops out
   assign colv      = {item.cell_bit, rd_data[1], rd_data[0]};
   assign window_in = {colv, window_ff[cgs_pkg::WIN_W-1:3]};
   assign wr_data   = {item.cell_bit, rd_data[1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (clear) begin
         window_ff <= '0;
      end else if (adv) begin
         window_ff <= window_in;
      end
   end

   // results that this cell completes
   always_comb begin
      group.row = item.row;
      group.col = item.col;
      group.mask[cgs_pkg::RES_UP_LEFT]  = item.row_ge1 && item.col_ge1;
      group.mask[cgs_pkg::RES_UP_HERE]  = item.row_ge1 && item.col_last;
      group.mask[cgs_pkg::RES_CUR_LEFT] = item.row_last && item.col_ge1;
      group.mask[cgs_pkg::RES_CUR_HERE] = item.row_last && item.col_last;
      group.vals[cgs_pkg::RES_UP_LEFT]  = cgs_pkg::smooth_at(window_in, 0, 0,
         item.row_ge1, item.row_ge2, item.col_ge1, item.col_ge2);
      group.vals[cgs_pkg::RES_UP_HERE]  = cgs_pkg::smooth_at(window_in, 0, 1,
         item.row_ge1, item.row_ge2, item.col_ge1, item.col_ge2);
      group.vals[cgs_pkg::RES_CUR_LEFT] = cgs_pkg::smooth_at(window_in, 1, 0,
         item.row_ge1, item.row_ge2, item.col_ge1, item.col_ge2);
      group.vals[cgs_pkg::RES_CUR_HERE] = cgs_pkg::smooth_at(window_in, 1, 1,
         item.row_ge1, item.row_ge2, item.col_ge1, item.col_ge2);
   end

endmodule

FILE: rtl/cgs_result_slot.sv
// Result slot: holds one cell's result group and sends its results one per transaction.
module cgs_result_slot (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  cgs_pkg::group_type   group_in,
   output logic                 take_ok,
   cgs_rsp_if.source            rsp
);

   cgs_pkg::group_type           group_ff;
   logic [cgs_pkg::RES_N-1:0]    mask_ff;
   logic [cgs_pkg::RES_N-1:0]    pick;
   logic [cgs_pkg::RES_N-1:0]    rest;
   logic [1:0]                   sel;
   logic                         rsp_acc;

   // lowest pending result goes first
   always_comb begin
      sel = cgs_pkg::RES_CUR_HERE;
      if (mask_ff[cgs_pkg::RES_UP_LEFT]) sel = cgs_pkg::RES_UP_LEFT;
      else if (mask_ff[cgs_pkg::RES_UP_HERE]) sel = cgs_pkg::RES_UP_HERE;
      else if (mask_ff[cgs_pkg::RES_CUR_LEFT]) sel = cgs_pkg::RES_CUR_LEFT;
      pick = cgs_pkg::RES_N'(1) << sel;
      rest = mask_ff & ~pick;
   end

   assign rsp_acc = rsp.valid && rsp.ready;
   assign take_ok = (mask_ff == '0) || ((rest == '0) && rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (load) begin
         mask_ff <= group_in.mask;
      end else if (rsp_acc) begin
         mask_ff <= rest;
      end
   end

   always_ff @(posedge clock) begin
      if (load) group_ff <= group_in;
   end

   assign rsp.valid      = (mask_ff != '0);
   assign rsp.cell_out   = group_ff.vals[sel];
   assign rsp.out_row    = (sel == cgs_pkg::RES_UP_LEFT || sel == cgs_pkg::RES_UP_HERE)
                           ? group_ff.row - cgs_pkg::ROW_W'(1) : group_ff.row;
   assign rsp.out_col    = (sel == cgs_pkg::RES_UP_HERE || sel == cgs_pkg::RES_CUR_HERE)
                           ? group_ff.col : group_ff.col - cgs_pkg::COL_W'(1);
   assign rsp.run_last   = (rest == '0);
   assign rsp.frame_done = (sel == cgs_pkg::RES_CUR_HERE);

endmodule

FILE: tb/tb_cave_grid_smoothing_pass.sv
// Testbench for the cave grid smoothing pass: random and directed grids against a predictor.
module tb_cave_grid_smoothing_pass;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int IDLE_PCT     = 22;
   localparam int SETTLE       = 16;
   localparam int HOLD_CYCLES  = 300;
   localparam int TOTAL_CELLS  = 360;

   // Index that no register answers to
   localparam logic [cgs_pkg::CSR_IDX_W-1:0] REG_UNUSED = cgs_pkg::CSR_IDX_W'(254);

   // One smoothed cell as it leaves the block
   typedef struct packed {
      logic                      cell_out;
      logic [cgs_pkg::ROW_W-1:0] row;
      logic [cgs_pkg::COL_W-1:0] col;
      logic                      run_last;
      logic                      frame_done;
   } smoothed_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cgs_req_if req_if();
   cgs_rsp_if rsp_if();
   cgs_csr_if csr_if();

   cave_grid_smoothing_pass uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always #5 clock = ~clock;

   // Stimulus and scoreboard storage
   logic         cell_queue[$];
   smoothed_type expected_cells[$];

   // Predictor state: sizes, position and the old grid as seen so far
   logic [cgs_pkg::SIZE_W-1:0] width_reg;
   logic [cgs_pkg::SIZE_W-1:0] height_reg;
   int                         row_pos;
   int                         col_pos;
   bit                         grid_img [0:cgs_pkg::MAX_HEIGHT-1][0:cgs_pkg::MAX_WIDTH-1];

   int   cycle_count  = 0;
   int   cells_queued = 0;
   int   cells_taken  = 0;
   int   results_seen = 0;
   int   reg_writes   = 0;
   int   fail_count   = 0;
   int   report_count = 0;
   int   hold_left    = 0;
   bit   hold_done    = 1'b0;
   logic calm;

   // Both sides run without idling over one stretch of the cell stream
   assign calm = (cells_taken >= 250) && (cells_taken < 370);

   function automatic int clamp_dim(input logic [cgs_pkg::SIZE_W-1:0] v, input int maxv);
      int d;
      d = int'(v);
      if (d < 1) d = 1;
      if (d > maxv) d = maxv;
      return d;
   endfunction

   // 4-5 rule at (er, ec) over the old grid; cells off the grid count as walls
   function automatic smoothed_type smoothed_at(input int er, input int ec,
                                                input int w, input int h);
      smoothed_type res;
      int walls;
      int nr;
      int nc;
      walls = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            nr = er + dr;
            nc = ec + dc;
            if (dr != 0 || dc != 0) begin
               if (nr < 0 || nr >= h || nc < 0 || nc >= w) walls++;
               else if (!grid_img[nr][nc]) walls++;
            end
         end
      end
      if (walls > cgs_pkg::KEEP_COUNT) res.cell_out = 1'b0;
      else if (walls < cgs_pkg::KEEP_COUNT) res.cell_out = 1'b1;
      else res.cell_out = grid_img[er][ec];
      res.row        = cgs_pkg::ROW_W'(er);
      res.col        = cgs_pkg::COL_W'(ec);
      res.run_last   = 1'b0;
      res.frame_done = 1'b0;
      return res;
   endfunction

   // Expected results for one accepted cell, in raster order
   function automatic void predict_cell(input logic cell_bit);
      smoothed_type found[cgs_pkg::RES_N];
      int w;
      int h;
      int r;
      int c;
      int n;
      w = clamp_dim(width_reg, cgs_pkg::MAX_WIDTH);
      h = clamp_dim(height_reg, cgs_pkg::MAX_HEIGHT);
      r = row_pos;
      c = col_pos;
      n = 0;
      grid_img[r][c] = cell_bit;
      if (r >= 1 && c >= 1) begin
         found[n] = smoothed_at(r - 1, c - 1, w, h);
         n++;
      end
      if (r >= 1 && c == w - 1) begin
         found[n] = smoothed_at(r - 1, c, w, h);
         n++;
      end
      if (r == h - 1 && c >= 1) begin
         found[n] = smoothed_at(r, c - 1, w, h);
         n++;
      end
      if (r == h - 1 && c == w - 1) begin
         found[n] = smoothed_at(r, c, w, h);
         found[n].frame_done = 1'b1;
         n++;
      end
      if (n > 0) found[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++) expected_cells.insert(expected_cells.size(), found[i]);
      // advance the raster position, wrapping to the next grid
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   // Register write: a known index sets a size and restarts the grid
   function automatic void apply_register(input logic [cgs_pkg::CSR_IDX_W-1:0] idx,
                                          input logic [cgs_pkg::SIZE_W-1:0] val);
      if (idx == cgs_pkg::REG_GRID_WIDTH) begin
         width_reg = val;
         row_pos = 0;
         col_pos = 0;
      end else if (idx == cgs_pkg::REG_GRID_HEIGHT) begin
         height_reg = val;
         row_pos = 0;
         col_pos = 0;
      end
   endfunction

   function automatic void check_result();
      smoothed_type got;
      smoothed_type want;
      got.cell_out   = rsp_if.cell_out;
      got.row        = rsp_if.out_row;
      got.col        = rsp_if.out_col;
      got.run_last   = rsp_if.run_last;
      got.frame_done = rsp_if.frame_done;
      if (expected_cells.size() == 0) begin
         fail_count++;
         if (report_count < 10) begin
            report_count++;
            $display("unexpected result: val=%0b row=%0d col=%0d last=%0b done=%0b",
                     got.cell_out, got.row, got.col, got.run_last, got.frame_done);
         end
      end else begin
         want = expected_cells.pop_front();
         if (got.cell_out !== want.cell_out || got.row !== want.row ||
             got.col !== want.col || got.run_last !== want.run_last ||
             got.frame_done !== want.frame_done) begin
            fail_count++;
            if (report_count < 10) begin
               report_count++;
               $display("mismatch at result %0d", results_seen);
               $display("   expected val=%0b row=%0d col=%0d last=%0b done=%0b",
                        want.cell_out, want.row, want.col, want.run_last,
                        want.frame_done);
               $display("   got      val=%0b row=%0d col=%0d last=%0b done=%0b",
                        got.cell_out, got.row, got.col, got.run_last, got.frame_done);
            end
         end
      end
   endfunction

   // Monitor: register writes, accepted cells and accepted results
   always @(posedge clock) begin
      if (reset) begin
         width_reg  = cgs_pkg::GRID_WIDTH_RST;
         height_reg = cgs_pkg::GRID_HEIGHT_RST;
         row_pos    = 0;
         col_pos    = 0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            apply_register(csr_if.index, csr_if.data);
            reg_writes++;
         end
         if (req_if.valid && req_if.ready) begin
            predict_cell(req_if.cell_in);
            cells_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            check_result();
            results_seen++;
         end
      end
   end

   // Cell driver, fed from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.cell_in <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (cell_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            req_if.valid   <= 1'b1;
            req_if.cell_in <= cell_queue.pop_front();
         end else begin
            req_if.valid   <= 1'b0;
            req_if.cell_in <= 1'($urandom_range(1));
         end
      end
   end

   // Result receiver, with one long hold-off while cells are still offered
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (!hold_done && results_seen >= 120 && req_if.valid) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_cells.size());
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_register(input logic [cgs_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [cgs_pkg::SIZE_W-1:0] val);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   task automatic add_cell(input logic v);
      cell_queue.insert(cell_queue.size(), v);
      cells_queued++;
   endtask

   task automatic queue_cells(input int n, input int open_pct);
      for (int i = 0; i < n; i++) add_cell($urandom_range(99) < open_pct);
   endtask

   // Sender pause: everything accepted, every result back, pipeline settled
   task automatic wait_drained(input int settle);
      do begin
         do @(posedge clock);
         while (cell_queue.size() != 0 || req_if.valid || expected_cells.size() != 0);
         repeat (settle) @(posedge clock);
      end while (cell_queue.size() != 0 || req_if.valid || expected_cells.size() != 0);
   endtask

   // Test sequence
   initial begin
      int phase;
      int wr;
      int hr;
      int w;
      int h;
      int n;
      csr_if.valid   = 1'b0;
      csr_if.index   = '0;
      csr_if.data    = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset sizes (64x64): first row plus a few cells of the second
      queue_cells(67, 50);
      wait_drained(SETTLE);

      // 3x3: an all-open grid, then an all-wall grid right behind it
      write_register(cgs_pkg::REG_GRID_WIDTH, cgs_pkg::SIZE_W'(3));
      write_register(cgs_pkg::REG_GRID_HEIGHT, cgs_pkg::SIZE_W'(3));
      queue_cells(9, 100);
      queue_cells(9, 0);
      wait_drained(SETTLE);

      // Unknown index at a grid boundary: sizes must stay as they are
      write_register(REG_UNUSED, 9'h1FF);

      // Zero sizes act as a single cell grid
      write_register(cgs_pkg::REG_GRID_WIDTH, cgs_pkg::SIZE_W'(0));
      write_register(cgs_pkg::REG_GRID_HEIGHT, cgs_pkg::SIZE_W'(0));
      add_cell(1'b1);
      add_cell(1'b0);
      add_cell(1'b1);
      wait_drained(SETTLE);

      // Single row of two
      write_register(cgs_pkg::REG_GRID_WIDTH, cgs_pkg::SIZE_W'(2));
      write_register(cgs_pkg::REG_GRID_HEIGHT, cgs_pkg::SIZE_W'(1));
      add_cell(1'b1);
      add_cell(1'b0);
      wait_drained(SETTLE);

      // Random small grids, leaving room for the full-width row
      phase = 0;
      while (cells_queued < TOTAL_CELLS - cgs_pkg::MAX_WIDTH) begin
         wr = $urandom_range(19);
         wr = (wr < 2) ? wr : $urandom_range(2, 7);
         hr = $urandom_range(19);
         hr = (hr < 2) ? hr : $urandom_range(2, 7);
         if ($urandom_range(99) < 80)
            write_register(cgs_pkg::REG_GRID_WIDTH, cgs_pkg::SIZE_W'(wr));
         if ($urandom_range(99) < 80)
            write_register(cgs_pkg::REG_GRID_HEIGHT, cgs_pkg::SIZE_W'(hr));
         @(posedge clock);
         w = clamp_dim(width_reg, cgs_pkg::MAX_WIDTH);
         h = clamp_dim(height_reg, cgs_pkg::MAX_HEIGHT);
         n = w * h;
         // sometimes stop mid-grid so the next write restarts it
         if (w * h > 1 && $urandom_range(99) < 25) n += $urandom_range(1, w * h - 1);
         queue_cells(n, $urandom_range(20, 80));
         wait_drained(SETTLE);
         phase++;
      end

      // oversize width clamps to the maximum, one row
      write_register(cgs_pkg::REG_GRID_WIDTH, 9'h1FF);
      write_register(cgs_pkg::REG_GRID_HEIGHT, cgs_pkg::SIZE_W'(1));
      queue_cells(cgs_pkg::MAX_WIDTH, $urandom_range(20, 80));
      wait_drained(2 * SETTLE);

      fail_count += expected_cells.size();
      $display("Covered %0d cells and %0d smoothed results over %0d register writes",
               cells_taken, results_seen, reg_writes);
      $display("in %0d random grid settings plus directed, reset-size and full-width grids.",
               phase);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d failures", fail_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
